// File: src/tst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Taylor tangent package
// Shared types, operation codes, status codes and fixed-point constants.
// ---------------------------------------------------------------------------
package tst_pkg;

	localparam int WORK_FRAC = 60;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] SEC_HALF_TURN = 64'd648000;
	localparam logic [63:0] PI_QUOT = PI_Q60 / SEC_HALF_TURN;
	localparam logic [63:0] PI_REM = PI_Q60 % SEC_HALF_TURN;
	localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

	// The half turn is 64 * 10125. The remainder product stays below 2^39, so
	// after dropping its low six bits it is below 2^33, and a multiply by
	// ceil(2^47 / 10125) followed by a shift of 47 gives the exact quotient.
	localparam int          X3_SHIFT = 47;
	localparam logic [63:0] X3_RECIP = ((64'd1 << 47) + 64'd10124) / 64'd10125;

	// Datapath operations.
	localparam logic [2:0] OP_X1  = 3'd0; // seconds times pi quotient
	localparam logic [2:0] OP_X2  = 3'd1; // seconds times pi remainder
	localparam logic [2:0] OP_X3  = 3'd2; // remainder product over half turn
	localparam logic [2:0] OP_TM1 = 3'd3; // term times angle, sine step
	localparam logic [2:0] OP_TD1 = 3'd4; // divide by odd index, update sine
	localparam logic [2:0] OP_TM2 = 3'd5; // term times angle, cosine step
	localparam logic [2:0] OP_TD2 = 3'd6; // divide by even index, update cosine
	localparam logic [2:0] OP_FD  = 3'd7; // final sine over cosine

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_COS = 2'd1;
	localparam logic [1:0] STAT_SAT = 2'd2;

	typedef struct packed {
		logic       load;
		logic       start;
		logic [2:0] op;
		logic [5:0] idx;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic cs_bad;
	} sts_t;

endpackage

// File: src/tst_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Taylor tangent multiplier
// 64 x 64 unsigned multiply, one 32 x 32 partial product per cycle.
// ---------------------------------------------------------------------------
module tst_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  a_part, b_part;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	always_comb begin
		a_part = cnt_q[0] ? a_q[63:32] : a_q[31:0];
		b_part = cnt_q[1] ? b_q[63:32] : b_q[31:0];
		pp = {32'd0, a_part} * {32'd0, b_part};
		case (cnt_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: src/tst_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Taylor tangent divider
// Restoring division, one quotient bit per cycle, with quotient overflow flag.
// ---------------------------------------------------------------------------
module tst_div #(
	parameter int NW = 96,
	parameter int CW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [63:0]   den,
	input  logic [CW-1:0] steps,
	output logic          done,
	output logic [63:0]   quot,
	output logic          ovf
);

	logic [NW-1:0] num_q;
	logic [63:0]   den_q, rem_q, q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q, ovf_q;
	logic [64:0]   r2;
	logic          fits;

	always_comb begin
		r2   = {rem_q, num_q[NW-1]};
		fits = r2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (q_q[63])
				ovf_q <= 1'b1;
			if (fits) begin
				rem_q <= 64'(r2 - {1'b0, den_q});
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= r2[63:0];
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign ovf  = ovf_q;

endmodule

// File: src/tst_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Taylor tangent datapath
// Angle, term and sum registers around a shared multiplier and divider.
// ---------------------------------------------------------------------------
module tst_dp
	import tst_pkg::*;
#(
	parameter int FRAC_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [6:0]  degrees,
	input  logic [5:0]  minutes,
	input  logic [5:0]  seconds,
	output sts_t        sts,
	output logic [63:0] res_tangent,
	output logic [1:0]  res_status
);

	localparam int NW = 64 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [19:0]   s_q;
	logic [63:0]   x_q, t_q, tmp_q, sn_q, cs_q, fq_q;
	logic          fovf_q;
	logic [2:0]    op_q;
	logic [63:0]   ma, mb, dnum, dden, mag;
	logic [CW-1:0] dsteps;
	logic          mul_go, div_go, mul_done, div_done, ovf, neg;
	logic [127:0]  prod;
	logic [63:0]   quot, limit, q_res;
	logic [6:0]    odd_k, even_k;

	always_comb begin
		neg    = sn_q[63];
		mag    = neg ? (64'd0 - sn_q) : sn_q;
		even_k = {cmd.idx, 1'b0};
		odd_k  = even_k - 7'd1;
		ma     = t_q;
		mb     = x_q;
		dnum   = t_q;
		dden   = {57'd0, odd_k};
		dsteps = CW'(64);
		mul_go = 1'b0;
		div_go = 1'b0;
		case (cmd.op)
			OP_X1: begin
				ma = {44'd0, s_q};
				mb = PI_QUOT;
				mul_go = 1'b1;
			end
			OP_X2: begin
				ma = {44'd0, s_q};
				mb = PI_REM;
				mul_go = 1'b1;
			end
			OP_X3: begin
				// Division by the half turn as a reciprocal multiplication.
				ma = {6'd0, tmp_q[63:6]};
				mb = X3_RECIP;
				mul_go = 1'b1;
			end
			OP_TM1, OP_TM2: mul_go = 1'b1;
			OP_TD1: div_go = 1'b1;
			OP_TD2: begin
				dden = {57'd0, even_k};
				div_go = 1'b1;
			end
			default: begin
				dnum = mag;
				dden = cs_q;
				dsteps = CW'(NW);
				div_go = 1'b1;
			end
		endcase
	end

	tst_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.start && mul_go),
		.a(ma), .b(mb), .done(mul_done), .prod(prod)
	);

	tst_div #(.NW(NW), .CW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start && div_go),
		.num({dnum, {FRAC_BITS{1'b0}}}), .den(dden), .steps(dsteps),
		.done(div_done), .quot(quot), .ovf(ovf)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q  <= ({13'd0, degrees} * 20'd3600)
				+ ({14'd0, minutes} * 20'd60) + {14'd0, seconds};
			sn_q <= '0;
			cs_q <= ONE_Q60;
			t_q  <= ONE_Q60;
		end
		if (cmd.start)
			op_q <= cmd.op;
		if (mul_done || div_done) begin
			case (op_q)
				OP_X1: x_q <= prod[63:0];
				OP_X2: tmp_q <= prod[63:0];
				OP_X3: x_q <= x_q + prod[X3_SHIFT+63:X3_SHIFT];
				OP_TM1, OP_TM2: t_q <= prod[WORK_FRAC+63:WORK_FRAC];
				OP_TD1: begin
					t_q  <= quot;
					sn_q <= cmd.idx[0] ? sn_q + quot : sn_q - quot;
				end
				OP_TD2: begin
					t_q  <= quot;
					cs_q <= cmd.idx[0] ? cs_q - quot : cs_q + quot;
				end
				default: begin
					fq_q   <= quot;
					fovf_q <= ovf;
				end
			endcase
		end
	end

	always_comb begin
		sts.done   = mul_done || div_done;
		sts.cs_bad = cs_q[63] || (cs_q == 64'd0);
		limit      = neg ? NEG_MIN : POS_MAX;
		q_res      = neg ? (64'd0 - fq_q) : fq_q;
		if (sts.cs_bad) begin
			res_tangent = limit;
			res_status  = STAT_COS;
		end else if (fovf_q || fq_q > limit) begin
			res_tangent = limit;
			res_status  = STAT_SAT;
		end else begin
			res_tangent = q_res;
			res_status  = STAT_OK;
		end
	end

endmodule

// File: src/tst_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Taylor tangent controller
// Sequences angle conversion, the term loop and, unless the cosine is bad, the final division.
// ---------------------------------------------------------------------------
module tst_ctrl
	import tst_pkg::*;
#(
	parameter int MAX_TERMS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [4:0] term_count,
	input  sts_t       sts,
	input  logic       out_free,
	output cmd_t       cmd,
	output logic       capture
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] op_q;
	logic [5:0] i_q, n_q, n_clamp;

	assign n_clamp = ({1'b0, term_count} > 6'(MAX_TERMS)) ? 6'(MAX_TERMS)
		: {1'b0, term_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_X1;
			i_q     <= 6'd1;
			n_q     <= 6'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					n_q     <= n_clamp;
					op_q    <= OP_X1;
					i_q     <= 6'd1;
					state_q <= ST_RUN;
				end
				ST_RUN: state_q <= ST_WAIT;
				ST_WAIT: if (sts.done) begin
					state_q <= ST_RUN;
					unique case (op_q)
						OP_X1:  op_q <= OP_X2;
						OP_X2:  op_q <= OP_X3;
						OP_X3: begin
							op_q <= OP_TM1;
							if (n_q == 6'd0)
								state_q <= ST_CHK;
						end
						OP_TM1: op_q <= OP_TD1;
						OP_TD1: op_q <= OP_TM2;
						OP_TM2: op_q <= OP_TD2;
						OP_TD2: begin
							op_q <= OP_TM1;
							if (i_q == n_q)
								state_q <= ST_CHK;
							else
								i_q <= i_q + 6'd1;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_CHK: begin
					if (sts.cs_bad) begin
						state_q <= ST_DONE;
					end else begin
						op_q    <= OP_FD;
						state_q <= ST_RUN;
					end
				end
				ST_DONE: if (out_free)
					state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		cmd.start = (state_q == ST_RUN);
		cmd.op    = op_q;
		cmd.idx   = i_q;
		capture   = (state_q == ST_DONE) && out_free;
	end

endmodule

// File: src/taylor_series_tangent_core.sv
`timescale 1ns / 1ps
// From accept to result an item passes through angle conversion, the term loop and,
// unless the cosine is bad, the final division; each of the n terms used costs two
// multiplies and two divisions. No new item is accepted until the last is captured.
// A finished result waits in the output register while the next item runs.
// Reset (arst_n low, asynchronous) idles the controller, empties the output
// and sets term_count to 8.
// ---------------------------------------------------------------------------
// Taylor series tangent core
// Converts degrees/minutes/seconds to radians, sums sine and cosine series
// and divides them to give a saturated signed Q31.32 tangent.
// ---------------------------------------------------------------------------
module taylor_series_tangent_core
	import tst_pkg::*;
#(
	parameter int MAX_TERMS = 16,
	parameter int FRAC_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // degrees[6:0], minutes[12:7], seconds[18:13], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // tangent[63:0]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data       // term_count
);

	// Always writable; change term count only while idle (the core does not enforce it).
	logic [4:0]  term_count_q;
	cmd_t        cmd;
	sts_t        sts;
	logic        out_free, capture;
	logic [63:0] res_tangent, tangent_q;
	logic [1:0]  res_status, status_q;
	logic        out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			term_count_q <= 5'd8;
		else if (cfg_valid)
			term_count_q <= cfg_data;
	end

	// The output slot is free when empty or being drained in this cycle.
	assign out_free = !out_valid_q || m_axis_tready;

	tst_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.term_count(term_count_q), .sts(sts), .out_free(out_free),
		.cmd(cmd), .capture(capture)
	);

	tst_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.degrees(s_axis_tdata[6:0]), .minutes(s_axis_tdata[12:7]),
		.seconds(s_axis_tdata[18:13]), .sts(sts),
		.res_tangent(res_tangent), .res_status(res_status)
	);

	// Output register holding one finished item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (capture)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			tangent_q <= res_tangent;
			status_q  <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tangent_q;
	assign m_axis_tuser  = status_q;

`ifndef SYNTHESIS
	a_capture_room: assert property (@(posedge clk) disable iff (!arst_n)
		capture |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result captured over an untaken item");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after accepting an item");
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !sts.done)
		else $error("unit finished one cycle after start");
	a_no_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !s_axis_tready)
		else $error("operation started while idle");
`endif

endmodule
